// ===== src/rmpd_pkg.sv =====
// Package for the region motion press detector.
// Holds shared widths, limits, state codes and controller interface types.
`timescale 1ns / 1ps
`default_nettype none
package rmpd_pkg;
  localparam int NUM_KEYS  = 16;
  localparam int KEY_W     = 4;
  localparam int LABEL_W   = 5;
  localparam int ROW_W     = 9;
  localparam int COLOR_W   = 8;
  localparam int DIST_W    = 18;
  localparam int COUNT_W   = 19;
  localparam int SUM_W     = 28;
  localparam int CENT_W    = 17;
  localparam int MOVE_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 19;
  localparam int FRAC_W    = 8;
  localparam int DIVD_W    = SUM_W + FRAC_W;
  localparam int DIV_CNT_W = 6;
  localparam int ENTRY_W   = COUNT_W + SUM_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [CENT_W-1:0]  CENT_MAX  = '1;
  localparam logic [KEY_W-1:0]   LAST_KEY  = KEY_W'(NUM_KEYS - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIVD_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD_SQ    = 2'd0,
    CFG_MIN_FRAME_MOTION = 2'd1,
    CFG_MIN_KEY_OVERLAP = 2'd2,
    CFG_MIN_MOVE_Q8     = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PIX_RD,
    S_PIX_WR,
    S_EOF_RD,
    S_EOF_CHK,
    S_EOF_DIV,
    S_EOF_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic k_zero;
    logic rd_pix;
    logic upd_pix;
    logic rd_key;
    logic chk_key;
    logic div_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has;
    logic div_done;
    logic out_free;
    logic k_last;
  } ctrl_status_t;
endpackage
`default_nettype wire

// ===== src/rmpd_ram.sv =====
// Generic single write port RAM with one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module rmpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== src/rmpd_ctrl.sv =====
// Controller state machine for the region motion press detector.
// Depends on rmpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmpd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  operation,
  output logic                       in_stall,
  output rmpd_pkg::ctrl_cmd_t        cmd,
  input  wire rmpd_pkg::ctrl_status_t status
);
  import rmpd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (operation) begin
            cmd.k_zero = 1'b1;
            state_next = S_EOF_RD;
          end else begin
            state_next = S_PIX_RD;
          end
        end
      end
      S_PIX_RD: begin
        cmd.rd_pix = 1'b1;
        state_next = S_PIX_WR;
      end
      S_PIX_WR: begin
        cmd.upd_pix = 1'b1;
        state_next = S_IDLE;
      end
      S_EOF_RD: begin
        cmd.rd_key = 1'b1;
        state_next = S_EOF_CHK;
      end
      S_EOF_CHK: begin
        cmd.chk_key = 1'b1;
        state_next = status.has ? S_EOF_DIV : S_EOF_OUT;
      end
      S_EOF_DIV: begin
        if (status.div_done) begin
          state_next = S_EOF_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_EOF_OUT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = status.k_last ? S_IDLE : S_EOF_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== src/rmpd_datapath.sv =====
// Datapath: configuration, motion test, per-key accumulation RAM, divider and
// result register. Depends on rmpd_pkg and rmpd_ram.
`timescale 1ns / 1ps
`default_nettype none
module rmpd_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write_en,
  input  wire logic [rmpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rmpd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [rmpd_pkg::COLOR_W-1:0]      cur_red,
  input  wire logic [rmpd_pkg::COLOR_W-1:0]      cur_green,
  input  wire logic [rmpd_pkg::COLOR_W-1:0]      cur_blue,
  input  wire logic [rmpd_pkg::COLOR_W-1:0]      old_red,
  input  wire logic [rmpd_pkg::COLOR_W-1:0]      old_green,
  input  wire logic [rmpd_pkg::COLOR_W-1:0]      old_blue,
  input  wire logic                              in_region,
  input  wire logic [rmpd_pkg::LABEL_W-1:0]      key_label,
  input  wire logic [rmpd_pkg::ROW_W-1:0]        row,
  input  wire rmpd_pkg::ctrl_cmd_t               cmd,
  output rmpd_pkg::ctrl_status_t                 status,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [rmpd_pkg::KEY_W-1:0]        key_index,
  output logic                                   pressed,
  output logic                                   has_centroid,
  output logic      [rmpd_pkg::CENT_W-1:0]       centroid_q8,
  output logic                                   last_key
);
  import rmpd_pkg::*;

  logic [DIST_W-1:0]  threshold_sq;
  logic [COUNT_W-1:0] min_frame_motion;
  logic [COUNT_W-1:0] min_key_overlap;
  logic [MOVE_W-1:0]  min_move_q8;

  logic [COLOR_W-1:0] cr, cg, cb, orr, og, ob;
  logic               region_q;
  logic [LABEL_W-1:0] label_q;
  logic [ROW_W-1:0]   row_q;
  logic               moving_q;

  logic [COUNT_W-1:0] frame_count;
  logic [NUM_KEYS-1:0] key_valid;
  logic               rd_valid_q;
  logic [KEY_W-1:0]   k;

  logic               ram_wr_en;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [KEY_W-1:0]   ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;
  logic [COUNT_W-1:0] ent_cnt;
  logic [SUM_W-1:0]   ent_sum;

  logic [COUNT_W-1:0] cnt_q;
  logic [COUNT_W-1:0] rem;
  logic [DIVD_W-1:0]  quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic               has_q;

  logic [CENT_W-1:0] last_cent [NUM_KEYS];
  logic [NUM_KEYS-1:0] last_valid;

  logic [DIST_W-1:0]  color_dist;
  logic [COUNT_W-1:0] cnt_new;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_new;
  logic [COUNT_W:0]   rem_sh;
  logic [CENT_W-1:0]  cent;
  logic [CENT_W:0]    limit;
  logic               has_comb;

  function automatic logic [2*COLOR_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_sq     <= DIST_W'(900);
      min_frame_motion <= COUNT_W'(50);
      min_key_overlap  <= COUNT_W'(50);
      min_move_q8      <= MOVE_W'(512);
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_THRESHOLD_SQ:     threshold_sq     <= cfg_data[DIST_W-1:0];
        CFG_MIN_FRAME_MOTION: min_frame_motion <= cfg_data[COUNT_W-1:0];
        CFG_MIN_KEY_OVERLAP:  min_key_overlap  <= cfg_data[COUNT_W-1:0];
        CFG_MIN_MOVE_Q8:      min_move_q8      <= cfg_data[MOVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cr <= cur_red;
      cg <= cur_green;
      cb <= cur_blue;
      orr <= old_red;
      og <= old_green;
      ob <= old_blue;
      region_q <= in_region;
      label_q <= key_label;
      row_q <= row;
    end
    if (cmd.rd_pix) begin
      moving_q <= (color_dist > threshold_sq) && region_q;
    end
  end

  assign color_dist = DIST_W'(sq_diff(cr, orr)) + DIST_W'(sq_diff(cg, og))
                    + DIST_W'(sq_diff(cb, ob));

  assign ram_rd_en   = cmd.rd_pix || cmd.rd_key;
  assign ram_rd_addr = cmd.rd_pix ? label_q[KEY_W-1:0] : k;

  rmpd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_KEYS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(label_q[KEY_W-1:0]),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  assign ent_cnt = rd_valid_q ? ram_rd_data[ENTRY_W-1:SUM_W] : '0;
  assign ent_sum = rd_valid_q ? ram_rd_data[SUM_W-1:0] : '0;
  assign cnt_new = (ent_cnt == COUNT_MAX) ? COUNT_MAX : ent_cnt + COUNT_W'(1);
  assign sum_wide = {1'b0, ent_sum} + (SUM_W + 1)'(row_q);
  assign sum_new = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign ram_wr_en = cmd.upd_pix && moving_q && !label_q[LABEL_W-1];
  assign ram_wr_data = {cnt_new, sum_new};

  assign has_comb = (frame_count > min_frame_motion) && (ent_cnt > min_key_overlap)
                  && (ent_cnt != '0);
  assign rem_sh = {rem, quo[DIVD_W-1]};
  assign cent = !has_q ? '0 :
                (quo[DIVD_W-1:CENT_W] != '0) ? CENT_MAX : quo[CENT_W-1:0];
  assign limit = {1'b0, last_cent[k]} + (CENT_W + 1)'(min_move_q8);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      key_valid <= '0;
      last_valid <= '0;
      out_valid <= 1'b0;
      k <= '0;
    end else begin
      if (ram_rd_en) begin
        rd_valid_q <= key_valid[ram_rd_addr];
      end
      if (cmd.upd_pix && moving_q) begin
        if (frame_count != COUNT_MAX) begin
          frame_count <= frame_count + COUNT_W'(1);
        end
        if (!label_q[LABEL_W-1]) begin
          key_valid[label_q[KEY_W-1:0]] <= 1'b1;
        end
      end
      if (cmd.k_zero) begin
        k <= '0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        key_index <= k;
        has_centroid <= has_q;
        centroid_q8 <= cent;
        pressed <= has_q && last_valid[k] && ({1'b0, cent} > limit);
        last_key <= (k == LAST_KEY);
        last_cent[k] <= cent;
        last_valid[k] <= has_q;
        key_valid[k] <= 1'b0;
        if (k == LAST_KEY) begin
          frame_count <= '0;
        end else begin
          k <= k + KEY_W'(1);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chk_key) begin
      has_q <= has_comb;
      cnt_q <= ent_cnt;
      quo <= {ent_sum, FRAC_W'(0)};
      rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
      if (rem_sh >= {1'b0, cnt_q}) begin
        rem <= COUNT_W'(rem_sh - {1'b0, cnt_q});
        quo <= {quo[DIVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[COUNT_W-1:0];
        quo <= {quo[DIVD_W-2:0], 1'b0};
      end
    end
  end

  assign status.has = has_comb;
  assign status.div_done = (div_cnt == DIV_STEPS);
  assign status.out_free = !out_valid || !out_stall;
  assign status.k_last = (k == LAST_KEY);
endmodule
`default_nettype wire

// ===== src/region_motion_press_detector.sv =====
// Pixel transaction: after acceptance the controller passes S_PIX_RD and
// S_PIX_WR before the next is accepted. End-of-frame transaction: per key
// S_EOF_RD, S_EOF_CHK, S_EOF_DIV if it gets a centroid, and S_EOF_OUT, which
// waits out any output stall; after the last key, back to S_IDLE. The serial
// divider makes one quotient bit per cycle. Synchronous reset clears the motion
// counter, k, valid flags and out_valid, and loads the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none
module region_motion_press_detector (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write_en,
  input  wire logic [rmpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rmpd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             operation,
  input  wire logic [rmpd_pkg::COLOR_W-1:0]     cur_red,
  input  wire logic [rmpd_pkg::COLOR_W-1:0]     cur_green,
  input  wire logic [rmpd_pkg::COLOR_W-1:0]     cur_blue,
  input  wire logic [rmpd_pkg::COLOR_W-1:0]     old_red,
  input  wire logic [rmpd_pkg::COLOR_W-1:0]     old_green,
  input  wire logic [rmpd_pkg::COLOR_W-1:0]     old_blue,
  input  wire logic                             in_region,
  input  wire logic [rmpd_pkg::LABEL_W-1:0]     key_label,
  input  wire logic [rmpd_pkg::ROW_W-1:0]       row,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [rmpd_pkg::KEY_W-1:0]       key_index,
  output logic                                  pressed,
  output logic                                  has_centroid,
  output logic      [rmpd_pkg::CENT_W-1:0]      centroid_q8,
  output logic                                  last_key
);
  import rmpd_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  rmpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .operation(operation),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  rmpd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cur_red     (cur_red),
    .cur_green   (cur_green),
    .cur_blue    (cur_blue),
    .old_red     (old_red),
    .old_green   (old_green),
    .old_blue    (old_blue),
    .in_region   (in_region),
    .key_label   (key_label),
    .row         (row),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .key_index   (key_index),
    .pressed     (pressed),
    .has_centroid(has_centroid),
    .centroid_q8 (centroid_q8),
    .last_key    (last_key)
  );
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking bench for region_motion_press_detector: pixel and end-of-frame
// transactions go in under random gaps and stalls, and each key report is checked
// against an in-bench detector model. Depends on rmpd_pkg and the block RTL.
`timescale 1ns / 1ps
module tb_top;
  import rmpd_pkg::*;

  typedef struct {
    logic              op;
    logic [COLOR_W-1:0] cr, cg, cb, orr, og, ob;
    logic              region;
    logic [LABEL_W-1:0] label;
    logic [ROW_W-1:0]   row;
  } pixel_t;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic              press;
    logic              has;
    logic [CENT_W-1:0] cent;
    logic              last;
  } report_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write_en = 0;
  cfg_index_t cfg_index = CFG_THRESHOLD_SQ;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic operation = 0;
  logic [COLOR_W-1:0] cur_red = 0, cur_green = 0, cur_blue = 0;
  logic [COLOR_W-1:0] old_red = 0, old_green = 0, old_blue = 0;
  logic in_region = 0;
  logic [LABEL_W-1:0] key_label = 0;
  logic [ROW_W-1:0] row = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [KEY_W-1:0] key_index;
  logic pressed, has_centroid, last_key;
  logic [CENT_W-1:0] centroid_q8;

  region_motion_press_detector dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  pixel_t pixel_stream[$];
  report_t key_reports[$];
  pixel_t on_bus;
  int errors = 0;
  bit calm = 0;

  // Detector model state.
  logic [DIST_W-1:0] thr;
  logic [COUNT_W-1:0] frame_min, key_min;
  logic [MOVE_W-1:0] move_min;
  logic [COUNT_W-1:0] motion_cnt;
  logic [COUNT_W-1:0] key_cnt[NUM_KEYS];
  logic [SUM_W-1:0] key_sum[NUM_KEYS];
  logic [CENT_W-1:0] prev_cent[NUM_KEYS];
  logic prev_has[NUM_KEYS];

  function automatic int unsigned sqd(logic [7:0] a, logic [7:0] b);
    int unsigned d;
    d = a > b ? a - b : b - a;
    return d * d;
  endfunction

  function automatic void absorb_pixel(pixel_t p);
    int unsigned d;
    d = sqd(p.cr, p.orr) + sqd(p.cg, p.og) + sqd(p.cb, p.ob);
    if (d > thr && p.region) begin
      if (motion_cnt != COUNT_MAX) motion_cnt++;
      if (p.label < NUM_KEYS) begin
        if (key_cnt[p.label] != COUNT_MAX) key_cnt[p.label]++;
        if ({1'b0, key_sum[p.label]} + p.row > {1'b0, SUM_MAX}) key_sum[p.label] = SUM_MAX;
        else key_sum[p.label] = key_sum[p.label] + p.row;
      end
    end
  endfunction

  function automatic void judge_frame();
    report_t r;
    logic [DIVD_W-1:0] q;
    bit judged;
    judged = motion_cnt > frame_min;
    for (int k = 0; k < NUM_KEYS; k++) begin
      r.key = k;
      r.has = judged && key_cnt[k] > key_min && key_cnt[k] != 0;
      r.cent = 0;
      r.press = 0;
      if (r.has) begin
        q = {key_sum[k], 8'b0} / key_cnt[k];
        r.cent = q > CENT_MAX ? CENT_MAX : q[CENT_W-1:0];
        r.press = prev_has[k] && ({1'b0, r.cent} > {1'b0, prev_cent[k]} + move_min);
      end
      r.last = (k == NUM_KEYS - 1);
      prev_cent[k] = r.cent;
      prev_has[k] = r.has;
      key_cnt[k] = 0;
      key_sum[k] = 0;
      key_reports = {key_reports, r};
    end
    motion_cnt = 0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver.
  int gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (on_bus.op) judge_frame();
        else absorb_pixel(on_bus);
      end
      if (!in_valid || !in_stall) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 0;
        end else if (pixel_stream.size() > 0) begin
          on_bus = pixel_stream.pop_front();
          operation <= on_bus.op;
          cur_red <= on_bus.cr;
          cur_green <= on_bus.cg;
          cur_blue <= on_bus.cb;
          old_red <= on_bus.orr;
          old_green <= on_bus.og;
          old_blue <= on_bus.ob;
          in_region <= on_bus.region;
          key_label <= on_bus.label;
          row <= on_bus.row;
          in_valid <= 1;
          gap = pick_gap();
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Monitor and output stall.
  int stall_left = 0;
  always @(posedge clk) begin
    report_t e;
    int g;
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (key_reports.size() == 0) begin
          $error("key report with none pending: key_index %0d", key_index);
          errors++;
        end else begin
          e = key_reports.pop_front();
          if (key_index !== e.key) begin
            $error("key_index expected %0d got %0d", e.key, key_index); errors++;
          end
          if (pressed !== e.press) begin
            $error("pressed expected %0d got %0d", e.press, pressed); errors++;
          end
          if (has_centroid !== e.has) begin
            $error("has_centroid expected %0d got %0d", e.has, has_centroid); errors++;
          end
          if (centroid_q8 !== e.cent) begin
            $error("centroid_q8 expected %0d got %0d", e.cent, centroid_q8); errors++;
          end
          if (last_key !== e.last) begin
            $error("last_key expected %0d got %0d", e.last, last_key); errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1;
      end else begin
        g = pick_gap();
        stall_left = g > 0 ? g - 1 : 0;
        out_stall <= (g > 0);
      end
    end
  end

  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet = 0;
    else quiet++;
    if (quiet >= 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_pixel(logic [7:0] cr, cg, cb, orr, og, ob, logic region,
                           logic [4:0] label, logic [8:0] r);
    pixel_t p;
    p.op = 0; p.cr = cr; p.cg = cg; p.cb = cb; p.orr = orr; p.og = og; p.ob = ob;
    p.region = region; p.label = label; p.row = r;
    pixel_stream = {pixel_stream, p};
  endtask

  task automatic add_eof();
    pixel_t p;
    p.op = 1; p.cr = $urandom; p.cg = $urandom; p.cb = $urandom;
    p.orr = $urandom; p.og = $urandom; p.ob = $urandom; p.region = $urandom;
    p.label = $urandom; p.row = $urandom;
    pixel_stream = {pixel_stream, p};
  endtask

  task automatic drain();
    wait (pixel_stream.size() == 0);
    @(posedge clk);
    wait (!in_valid && key_reports.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_write_en <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write_en <= 0;
    case (idx)
      CFG_THRESHOLD_SQ: thr = v[DIST_W-1:0];
      CFG_MIN_FRAME_MOTION: frame_min = v;
      CFG_MIN_KEY_OVERLAP: key_min = v;
      default: move_min = v[MOVE_W-1:0];
    endcase
  endtask

  task automatic configure(int t, int f, int k, int m);
    write_reg(CFG_THRESHOLD_SQ, t);
    write_reg(CFG_MIN_FRAME_MOTION, f);
    write_reg(CFG_MIN_KEY_OVERLAP, k);
    write_reg(CFG_MIN_MOVE_Q8, m);
  endtask

  // Frames of random pixels whose rows drift down so that presses occur.
  task automatic random_frames(int frames, int keys);
    int base;
    logic [7:0] c[3];
    base = $urandom_range(0, 300);
    for (int f = 0; f < frames; f++) begin
      base = (base + $urandom_range(0, 12)) % 500;
      repeat ($urandom_range(1, 14)) begin
        foreach (c[i]) c[i] = $urandom;
        if ($urandom_range(0, 3) == 0)
          add_pixel(c[0], c[1], c[2], $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
        else
          add_pixel(c[0], c[1], c[2], ~c[0], c[1] ^ 8'h80, $urandom,
                    $urandom_range(0, 9) != 0, $urandom_range(0, keys - 1),
                    base + $urandom_range(0, 8));
      end
      add_eof();
    end
  endtask

  initial begin
    thr = 900; frame_min = 50; key_min = 50; move_min = 512;
    motion_cnt = 0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_cnt[k] = 0; key_sum[k] = 0; prev_cent[k] = 0; prev_has[k] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 0;

    add_pixel(255, 255, 255, 0, 0, 0, 1, 0, 511);
    add_pixel(0, 0, 0, 255, 255, 255, 1, 15, 0);
    add_pixel(0, 0, 0, 255, 255, 255, 0, 3, 100);
    add_pixel(200, 10, 0, 0, 10, 200, 1, 16, 50);
    add_pixel(200, 10, 0, 0, 10, 200, 1, 31, 50);
    add_pixel(30, 0, 0, 0, 0, 0, 1, 2, 7);
    add_pixel(31, 0, 0, 0, 0, 0, 1, 2, 7);
    add_eof();
    drain();
    configure(0, 0, 0, 0);
    add_pixel(1, 0, 0, 0, 0, 0, 1, 0, 10);
    add_pixel(0, 0, 0, 0, 0, 0, 1, 1, 10);
    add_pixel(170, 85, 255, 85, 170, 0, 1, 5, 511);
    add_eof();
    add_pixel(1, 0, 0, 0, 0, 0, 1, 0, 20);
    add_pixel(2, 0, 0, 0, 0, 0, 1, 0, 21);
    add_pixel(200, 0, 0, 0, 0, 0, 1, 5, 0);
    add_eof();
    add_eof();
    drain();

    calm = 1;
    random_frames(6, 4);
    drain();
    calm = 0;
    random_frames(16, 4);
    drain();
    configure(195075, 262144, 262144, 131071);
    random_frames(4, 16);
    drain();
    configure($urandom_range(0, 20000), 4, 2, 300);
    random_frames(18, 3);
    drain();
    configure(900, 1, 1, $urandom_range(0, 1500));
    random_frames(14, 16);
    drain();

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
